@@ rtl/psl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the per-second peak level statistics block.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int SECONDS = 8;
  localparam int LEVEL_W = 16;
  localparam int IDX_W   = (SECONDS > 1) ? $clog2(SECONDS) : 1;
  localparam int CNT_W   = $clog2(SECONDS + 1);

  // middle entries of the sorted store, equal when the slot count is odd
  localparam int MID_LO_IDX = (SECONDS - 1) / 2;
  localparam int MID_HI_IDX = SECONDS / 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic signed [LEVEL_W-1:0] level_t;

  // -120 dB in Q8.8
  localparam level_t FLOOR_LEVEL = 16'sh8800;

  localparam logic [15:0] INTERVAL_RESET = 16'd1000;

  // register word index on the configuration port
  localparam logic [PADDR_W-3:0] REG_INTERVAL = '0;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FRAME  = 2'd2,
    CMD_TIME   = 2'd3
  } psl_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEAK,
    S_SORT,
    S_DONE
  } psl_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  tag;
    logic [31:0] time_ms;
    level_t      level;
  } psl_in_t;

  typedef struct packed {
    logic        interval_closed;
    logic        is_active;
    logic        is_complete;
    logic [7:0]  session_tag;
    logic [3:0]  intervals_done;
    level_t      last_peak;
    level_t      min_level;
    level_t      median_level;
    level_t      max_level;
  } psl_out_t;

  typedef struct packed {
    level_t min_level;
    level_t mid_lo;
    level_t mid_hi;
    level_t max_level;
  } psl_stats_t;

endpackage
`default_nettype wire

@@ rtl/psl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psl_ram
// Single write port, single read port RAM with registered read data.
// Read-first on a same-address write; entries never written read RESET_VAL.
// ----------------------------------------------------------------------------
module psl_ram #(
  parameter int                DEPTH     = 8,
  parameter int                WIDTH     = 16,
  parameter logic [WIDTH-1:0]  RESET_VAL = '0,
  localparam int               AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : RESET_VAL;

endmodule
`default_nettype wire

@@ rtl/psl_sorter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psl_sorter
// Keeps the sorted copy of the slot store in a RAM. One pass reads every
// entry in order and writes back the list with the old value taken out and
// the new value merged in, capturing min, middle and max on the way.
// ----------------------------------------------------------------------------
module psl_sorter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start_i,
  input  wire psl_pkg::level_t     old_i,
  input  wire psl_pkg::level_t     new_i,
  output logic                     done_o,
  output psl_pkg::psl_stats_t      stats_o
);

  localparam int N     = psl_pkg::SECONDS;
  localparam int IDX_W = psl_pkg::IDX_W;
  localparam int CNT_W = psl_pkg::CNT_W;

  logic                 busy_r, busy_nxt;
  logic                 pend_r, pend_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]     wr_cnt_r, wr_cnt_nxt;
  logic                 removed_r, removed_nxt;
  logic                 inserted_r, inserted_nxt;
  logic                 carry_v_r, carry_v_nxt;
  psl_pkg::level_t      carry_r, carry_nxt;
  psl_pkg::level_t      old_r, new_r;
  psl_pkg::psl_stats_t  stats_r, stats_nxt;

  logic                 issue;
  logic                 emit;
  psl_pkg::level_t      emit_val;
  psl_pkg::level_t      rd_data;

  psl_ram #(
    .DEPTH     (N),
    .WIDTH     (psl_pkg::LEVEL_W),
    .RESET_VAL (psl_pkg::FLOOR_LEVEL)
  ) u_sorted_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (emit),
    .waddr (wr_cnt_r[IDX_W-1:0]),
    .wdata (emit_val),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign issue = busy_r && (rd_cnt_r < CNT_W'(N));

  always_comb begin
    psl_pkg::level_t y;
    logic            want;
    y            = carry_r;
    want         = 1'b0;
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    pend_nxt     = issue;
    rd_cnt_nxt   = issue ? rd_cnt_r + CNT_W'(1) : rd_cnt_r;
    removed_nxt  = removed_r;
    inserted_nxt = inserted_r;
    carry_v_nxt  = carry_v_r;
    carry_nxt    = carry_r;

    if (pend_r) begin
      if (!removed_r && rd_data == old_r) begin
        // drop the overwritten value, release a held entry in its place
        removed_nxt = 1'b1;
        if (carry_v_r) begin
          want        = 1'b1;
          y           = carry_r;
          carry_v_nxt = 1'b0;
        end
      end else if (!inserted_r && rd_data > new_r) begin
        inserted_nxt = 1'b1;
        want         = 1'b1;
        y            = new_r;
        carry_nxt    = rd_data;
        carry_v_nxt  = 1'b1;
      end else if (carry_v_r) begin
        want      = 1'b1;
        y         = carry_r;
        carry_nxt = rd_data;
      end else begin
        want = 1'b1;
        y    = rd_data;
      end
    end else if (busy_r && !issue) begin
      // tail of the pass
      if (!inserted_r) begin
        want         = 1'b1;
        y            = new_r;
        inserted_nxt = 1'b1;
      end else if (carry_v_r) begin
        want        = 1'b1;
        y           = carry_r;
        carry_v_nxt = 1'b0;
      end
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end

    emit       = want && (wr_cnt_r < CNT_W'(N));
    emit_val   = y;
    wr_cnt_nxt = emit ? wr_cnt_r + CNT_W'(1) : wr_cnt_r;

    stats_nxt = stats_r;
    if (emit) begin
      if (wr_cnt_r == CNT_W'(0))              stats_nxt.min_level = y;
      if (wr_cnt_r == CNT_W'(psl_pkg::MID_LO_IDX)) stats_nxt.mid_lo = y;
      if (wr_cnt_r == CNT_W'(psl_pkg::MID_HI_IDX)) stats_nxt.mid_hi = y;
      if (wr_cnt_r == CNT_W'(N - 1))          stats_nxt.max_level = y;
    end

    if (start_i) begin
      busy_nxt     = 1'b1;
      pend_nxt     = 1'b0;
      rd_cnt_nxt   = '0;
      wr_cnt_nxt   = '0;
      removed_nxt  = 1'b0;
      inserted_nxt = 1'b0;
      carry_v_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pend_r     <= 1'b0;
      done_r     <= 1'b0;
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
      removed_r  <= 1'b0;
      inserted_r <= 1'b0;
      carry_v_r  <= 1'b0;
      stats_r    <= {4{psl_pkg::FLOOR_LEVEL}};
    end else begin
      busy_r     <= busy_nxt;
      pend_r     <= pend_nxt;
      done_r     <= done_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      wr_cnt_r   <= wr_cnt_nxt;
      removed_r  <= removed_nxt;
      inserted_r <= inserted_nxt;
      carry_v_r  <= carry_v_nxt;
      stats_r    <= stats_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (start_i) begin
      old_r <= old_i;
      new_r <= new_i;
    end
  end

  assign done_o  = done_r;
  assign stats_o = stats_r;

  // a write never lands on an entry that has not been read yet
  a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> wr_cnt_r < rd_cnt_r)
    else $error("sorted store written ahead of the read pointer");

  // every pass rewrites the whole store
  a_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> wr_cnt_r == CNT_W'(N))
    else $error("sort pass ended with a short write count");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("sort pass started while busy");

endmodule
`default_nettype wire

@@ rtl/per_second_peak_level_statistics.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_second_peak_level_statistics
// Calibration session tracker: per-interval peaks of frame levels go into a
// slot store, with min, median and max kept over a sorted copy.
//
// Input beats (in_valid/in_stall, in_data) carry one command each: start,
// cancel, frame level or time check. Every accepted beat gives exactly one
// result beat on out_valid/out_stall/out_data, in order.
// Start, cancel, frame and a time check that closes nothing go from accept
// straight to DONE; no new beat is taken until the last result is loaded.
// A time check that closes an interval reads and rewrites the slot RAM, then
// goes through PEAK and SORT, where the sorter walks the sorted RAM once,
// one entry per cycle, before DONE hands its result to the output register.
// The result sits in an output register; while the receiver stalls, the next
// beat is still taken and worked on, and its result waits until the register
// frees. in_stall is high while a beat is in progress.
// Reset clears the session, sets interval_ms to 1000 and makes every slot and
// sorted entry read -120 dB at once (valid bits, no clearing pass).
// interval_ms sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module per_second_peak_level_statistics (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire psl_pkg::psl_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output psl_pkg::psl_out_t                  out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [psl_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [psl_pkg::PDATA_W-1:0]   pwdata,
  output logic      [psl_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int N     = psl_pkg::SECONDS;
  localparam int IDX_W = psl_pkg::IDX_W;
  localparam int CNT_W = psl_pkg::CNT_W;

  psl_pkg::psl_state_t  state_r, state_nxt;

  logic [15:0]          interval_r;
  logic                 active_r;
  logic                 complete_r;
  logic [7:0]           tag_r;
  logic [31:0]          start_r;
  logic [CNT_W-1:0]     count_r;
  psl_pkg::level_t      run_peak_r;
  psl_pkg::level_t      last_peak_r;
  logic                 closed_r;

  logic                 out_valid_r;
  psl_pkg::psl_out_t    out_data_r;

  logic                 in_acc;
  logic                 close;
  logic [31:0]          elapsed;
  logic                 sort_start;
  logic                 sort_done;
  logic                 out_load;
  logic                 reg_wr;
  psl_pkg::level_t      old_peak;
  psl_pkg::psl_stats_t  stats;
  logic signed [16:0]   mid_sum;
  psl_pkg::psl_out_t    result;

  // configuration port
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite &&
                  (paddr[psl_pkg::PADDR_W-1:2] == psl_pkg::REG_INTERVAL);

  always_comb begin
    prdata = '0;
    if (paddr[psl_pkg::PADDR_W-1:2] == psl_pkg::REG_INTERVAL) begin
      prdata = psl_pkg::PDATA_W'(interval_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= psl_pkg::INTERVAL_RESET;
    end else if (reg_wr) begin
      interval_r <= pwdata[15:0];
    end
  end

  assign in_acc  = in_valid && !in_stall;
  assign elapsed = in_data.time_ms - start_r;
  assign close   = (in_data.cmd == psl_pkg::CMD_TIME) && active_r &&
                   (elapsed >= 32'(interval_r)) && (count_r < CNT_W'(N));

  // slot store, read-first so the overwritten peak comes out next cycle
  psl_ram #(
    .DEPTH     (N),
    .WIDTH     (psl_pkg::LEVEL_W),
    .RESET_VAL (psl_pkg::FLOOR_LEVEL)
  ) u_peak_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_acc && close),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (run_peak_r),
    .raddr (count_r[IDX_W-1:0]),
    .rdata (old_peak)
  );

  psl_sorter u_sorter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sort_start),
    .old_i   (old_peak),
    .new_i   (last_peak_r),
    .done_o  (sort_done),
    .stats_o (stats)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = close ? psl_pkg::S_PEAK : psl_pkg::S_DONE;
        end
      end
      psl_pkg::S_PEAK: state_nxt = psl_pkg::S_SORT;
      psl_pkg::S_SORT: begin
        if (sort_done) begin
          state_nxt = psl_pkg::S_DONE;
        end
      end
      psl_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = psl_pkg::S_IDLE;
        end
      end
      default: state_nxt = psl_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    sort_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      psl_pkg::S_IDLE: in_stall = 1'b0;
      psl_pkg::S_PEAK: sort_start = 1'b1;
      psl_pkg::S_SORT: ;
      psl_pkg::S_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // session state, updated at the accept edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      complete_r  <= 1'b0;
      tag_r       <= '0;
      start_r     <= '0;
      count_r     <= '0;
      run_peak_r  <= psl_pkg::FLOOR_LEVEL;
      last_peak_r <= psl_pkg::FLOOR_LEVEL;
      closed_r    <= 1'b0;
    end else if (in_acc) begin
      closed_r <= close;
      unique case (psl_pkg::psl_cmd_t'(in_data.cmd))
        psl_pkg::CMD_START: begin
          tag_r       <= in_data.tag;
          start_r     <= in_data.time_ms;
          count_r     <= '0;
          run_peak_r  <= psl_pkg::FLOOR_LEVEL;
          last_peak_r <= psl_pkg::FLOOR_LEVEL;
          active_r    <= 1'b1;
          complete_r  <= 1'b0;
        end
        psl_pkg::CMD_CANCEL: begin
          active_r   <= 1'b0;
          complete_r <= 1'b0;
          tag_r      <= '0;
        end
        psl_pkg::CMD_FRAME: begin
          if (active_r && in_data.level > run_peak_r) begin
            run_peak_r <= in_data.level;
          end
        end
        psl_pkg::CMD_TIME: begin
          if (close) begin
            count_r     <= count_r + CNT_W'(1);
            last_peak_r <= run_peak_r;
            run_peak_r  <= psl_pkg::FLOOR_LEVEL;
            start_r     <= in_data.time_ms;
            if (count_r + CNT_W'(1) >= CNT_W'(N)) begin
              active_r   <= 1'b0;
              complete_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // floor of the mean of the middle pair; same entry twice for an odd count
  assign mid_sum = {stats.mid_lo[15], stats.mid_lo} + {stats.mid_hi[15], stats.mid_hi};

  always_comb begin
    result.interval_closed = closed_r;
    result.is_active       = active_r;
    result.is_complete     = complete_r;
    result.session_tag     = tag_r;
    result.intervals_done  = 4'(count_r);
    result.last_peak       = last_peak_r;
    result.min_level       = stats.min_level;
    result.median_level    = mid_sum[16:1];
    result.max_level       = stats.max_level;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> !active_r)
    else $error("session complete and active at once");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(N))
    else $error("stored interval count beyond slot count");

  a_sort_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sort_done |-> state_r == psl_pkg::S_SORT)
    else $error("sort pass finished outside the wait state");

  a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !close) |=> state_r == psl_pkg::S_DONE)
    else $error("beat without a close did not go straight to result");

endmodule
`default_nettype wire

@@ dv/tb_per_second_peak_level_statistics.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_second_peak_level_statistics
// Drives start, cancel, frame and time check beats into the peak level
// statistics block. A built-in session tracker predicts every result beat.
// Runs directed sessions, the interval register extremes and random sessions
// under random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_per_second_peak_level_statistics;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [psl_pkg::PADDR_W-1:0] INTERVAL_ADDR = {psl_pkg::REG_INTERVAL, 2'b00};
  localparam logic [psl_pkg::PADDR_W-1:0] UNMAPPED_ADDR = {~psl_pkg::REG_INTERVAL, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psl_pkg::psl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  psl_pkg::psl_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [psl_pkg::PADDR_W-1:0] paddr = '0;
  logic [psl_pkg::PDATA_W-1:0] pwdata = '0;
  logic [psl_pkg::PDATA_W-1:0] prdata;
  logic pready;

  per_second_peak_level_statistics dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // session tracker state
  logic [15:0] interval_cfg;
  logic active_flag;
  logic complete_flag;
  logic [7:0] cur_tag;
  logic [31:0] ivl_start;
  int n_stored;
  psl_pkg::level_t run_peak;
  psl_pkg::level_t slot_peak[psl_pkg::SECONDS];
  psl_pkg::level_t slot_sorted[psl_pkg::SECONDS];

  psl_pkg::psl_out_t pending_results[$];
  psl_pkg::psl_out_t want_beat;
  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int idle_max = 11;

  function automatic void reset_session_model();
    interval_cfg = psl_pkg::INTERVAL_RESET;
    active_flag = 1'b0;
    complete_flag = 1'b0;
    cur_tag = '0;
    ivl_start = '0;
    n_stored = 0;
    run_peak = psl_pkg::FLOOR_LEVEL;
    for (int i = 0; i < psl_pkg::SECONDS; i++) begin
      slot_peak[i] = psl_pkg::FLOOR_LEVEL;
      slot_sorted[i] = psl_pkg::FLOOR_LEVEL;
    end
  endfunction

  // drop the overwritten value from the sorted copy, then insert the new peak
  function automatic void resort_slots(psl_pkg::level_t old_val, psl_pkg::level_t new_val);
    int pos;
    int i;
    bit found;
    pos = psl_pkg::SECONDS - 1;
    found = 1'b0;
    for (i = 0; i < psl_pkg::SECONDS; i++) begin
      if (!found && slot_sorted[i] == old_val) begin
        pos = i;
        found = 1'b1;
      end
    end
    for (i = pos; i < psl_pkg::SECONDS - 1; i++) slot_sorted[i] = slot_sorted[i + 1];
    i = psl_pkg::SECONDS - 1;
    while (i > 0 && slot_sorted[i - 1] > new_val) begin
      slot_sorted[i] = slot_sorted[i - 1];
      i--;
    end
    slot_sorted[i] = new_val;
  endfunction

  function automatic psl_pkg::psl_out_t compute_session_result(psl_pkg::psl_in_t item);
    psl_pkg::psl_out_t r;
    logic [31:0] elapsed;
    psl_pkg::level_t old_val;
    int mid_sum;
    r = '0;
    case (psl_pkg::psl_cmd_t'(item.cmd))
      psl_pkg::CMD_START: begin
        cur_tag = item.tag;
        ivl_start = item.time_ms;
        n_stored = 0;
        run_peak = psl_pkg::FLOOR_LEVEL;
        active_flag = 1'b1;
        complete_flag = 1'b0;
      end
      psl_pkg::CMD_CANCEL: begin
        active_flag = 1'b0;
        complete_flag = 1'b0;
        cur_tag = '0;
      end
      psl_pkg::CMD_FRAME: begin
        if (active_flag && item.level > run_peak) run_peak = item.level;
      end
      default: begin
        elapsed = item.time_ms - ivl_start;
        if (active_flag && elapsed >= {16'd0, interval_cfg} &&
            n_stored < psl_pkg::SECONDS) begin
          old_val = slot_peak[n_stored];
          slot_peak[n_stored] = run_peak;
          resort_slots(old_val, run_peak);
          n_stored++;
          run_peak = psl_pkg::FLOOR_LEVEL;
          ivl_start = item.time_ms;
          r.interval_closed = 1'b1;
          if (n_stored >= psl_pkg::SECONDS) begin
            active_flag = 1'b0;
            complete_flag = 1'b1;
          end
        end
      end
    endcase
    r.is_active = active_flag;
    r.is_complete = complete_flag;
    r.session_tag = cur_tag;
    r.intervals_done = 4'(n_stored);
    r.last_peak = (n_stored == 0) ? psl_pkg::FLOOR_LEVEL : slot_peak[n_stored - 1];
    r.min_level = slot_sorted[0];
    r.max_level = slot_sorted[psl_pkg::SECONDS - 1];
    // arithmetic shift gives the floor of the halved sum
    mid_sum = int'(slot_sorted[psl_pkg::MID_LO_IDX]) + int'(slot_sorted[psl_pkg::MID_HI_IDX]);
    r.median_level = psl_pkg::level_t'(mid_sum >>> 1);
    return r;
  endfunction

  task automatic send_item(input psl_pkg::psl_in_t item);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compute_session_result(item));
    items_sent++;
  endtask

  task automatic send_beat(input psl_pkg::psl_cmd_t c, input logic [7:0] tag,
                           input logic [31:0] t, input psl_pkg::level_t lvl);
    psl_pkg::psl_in_t item;
    item.cmd = c;
    item.tag = tag;
    item.time_ms = t;
    item.level = lvl;
    send_item(item);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write one register over apb and read it back when it is mapped
  task automatic program_interval(input logic [psl_pkg::PADDR_W-1:0] addr,
                                  input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == INTERVAL_ADDR) begin
      interval_cfg = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[15:0] !== value) begin
        $error("interval_ms readback: expected %0d, actual %0d", value, prdata[15:0]);
        errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic psl_pkg::level_t random_level();
    if ($urandom_range(0, 3) == 0) return psl_pkg::level_t'($urandom);
    return psl_pkg::level_t'(-int'($urandom_range(0, 30720)));
  endfunction

  task automatic test_directed_session();
    logic [31:0] t;
    idle_max = 11;
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh7FFF);
    send_beat(psl_pkg::CMD_TIME, 8'h00, 32'hFFFF_FFFF, 16'sh0000);
    send_beat(psl_pkg::CMD_CANCEL, 8'hFF, 32'h0, 16'sh8000);
    // interval spans the 32-bit time wrap
    t = 32'hFFFF_FE00;
    send_beat(psl_pkg::CMD_START, 8'hFF, t, 16'sh0000);
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh7FFF);
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh8000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd999, 16'sh0000);
    t = t + 32'd1000;
    send_beat(psl_pkg::CMD_TIME, 8'h00, t, 16'sh0000);
    // below -120 dB leaves the running peak at the floor
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh8000);
    t = t + 32'd1000;
    send_beat(psl_pkg::CMD_TIME, 8'h00, t, 16'sh0000);
    // restart while active keeps old slots in the statistics
    send_beat(psl_pkg::CMD_START, 8'h5A, t, 16'sh0000);
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh0000);
    t = t + 32'd1000;
    send_beat(psl_pkg::CMD_TIME, 8'h00, t, 16'sh0000);
    send_beat(psl_pkg::CMD_CANCEL, 8'h00, 32'h0, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd5000, 16'sh0000);
    // full session up to completion
    t = 32'h0;
    send_beat(psl_pkg::CMD_START, 8'h00, t, 16'sh0000);
    for (int k = 0; k < psl_pkg::SECONDS; k++) begin
      t = t + 32'd1000;
      send_beat(psl_pkg::CMD_TIME, 8'h00, t, 16'sh0000);
    end
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh7FFF);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd2000, 16'sh0000);
    wait_quiet();
  endtask

  task automatic test_interval_extremes();
    logic [31:0] t;
    idle_max = 0;
    program_interval(INTERVAL_ADDR, 16'd1);
    t = 32'h8000_0000;
    send_beat(psl_pkg::CMD_START, 8'hA5, t, 16'sh0000);
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh0100);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd1, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd1, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd2, 16'sh0000);
    wait_quiet();
    idle_max = 11;
    program_interval(INTERVAL_ADDR, 16'hFFFF);
    // a write past the register list must leave the interval alone
    program_interval(UNMAPPED_ADDR, 16'd5);
    t = 32'h0000_0010;
    send_beat(psl_pkg::CMD_START, 8'h3C, t, 16'sh0000);
    send_beat(psl_pkg::CMD_FRAME, 8'h00, 32'h0, 16'sh7FFF);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd5, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd65534, 16'sh0000);
    send_beat(psl_pkg::CMD_TIME, 8'h00, t + 32'd65535, 16'sh0000);
    send_beat(psl_pkg::CMD_CANCEL, 8'h00, 32'h0, 16'sh0000);
    wait_quiet();
  endtask

  task automatic random_session();
    logic [31:0] now;
    int n_ivl;
    int span;
    span = int'(interval_cfg);
    if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 3 * span);
    else now = $urandom;
    send_beat(psl_pkg::CMD_START, 8'($urandom), now, random_level());
    n_ivl = $urandom_range(1, psl_pkg::SECONDS + 2);
    for (int k = 0; k < n_ivl; k++) begin
      for (int j = $urandom_range(0, 4); j > 0; j--)
        send_beat(psl_pkg::CMD_FRAME, 8'($urandom), $urandom, random_level());
      if ($urandom_range(0, 2) == 0)
        send_beat(psl_pkg::CMD_TIME, 8'($urandom), now + $urandom_range(0, span - 1),
                  random_level());
      now = now + span + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 50));
      send_beat(psl_pkg::CMD_TIME, 8'($urandom), now, random_level());
      if ($urandom_range(0, 40) == 0)
        send_beat(psl_pkg::CMD_CANCEL, 8'($urandom), $urandom, random_level());
      if ($urandom_range(0, 40) == 0)
        send_beat(psl_pkg::CMD_START, 8'($urandom), now, random_level());
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] settings[4];
    int phase_end;
    psl_pkg::psl_in_t noise;
    settings[0] = 16'd1;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(2, 200));
    settings[3] = 16'($urandom_range(1, 65535));
    foreach (settings[p]) begin
      program_interval(INTERVAL_ADDR, settings[p]);
      phase_end = items_sent + 275;
      while (items_sent < phase_end) begin
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
        if ($urandom_range(0, 6) == 0) begin
          for (int j = $urandom_range(1, 5); j > 0; j--) begin
            noise = psl_pkg::psl_in_t'({$urandom, $urandom, $urandom});
            send_item(noise);
          end
        end else begin
          random_session();
        end
        // hold the sender until the block has drained
        if ($urandom_range(0, 9) == 0) wait_quiet();
      end
      wait_quiet();
    end
  endtask

  // result side: random stall before each beat
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want_beat = pending_results.pop_front();
        check_field("interval_closed", int'(want_beat.interval_closed),
                    int'(out_data.interval_closed));
        check_field("is_active", int'(want_beat.is_active), int'(out_data.is_active));
        check_field("is_complete", int'(want_beat.is_complete), int'(out_data.is_complete));
        check_field("session_tag", int'(want_beat.session_tag), int'(out_data.session_tag));
        check_field("intervals_done", int'(want_beat.intervals_done),
                    int'(out_data.intervals_done));
        check_field("last_peak", int'(want_beat.last_peak), int'(out_data.last_peak));
        check_field("min_level", int'(want_beat.min_level), int'(out_data.min_level));
        check_field("median_level", int'(want_beat.median_level),
                    int'(out_data.median_level));
        check_field("max_level", int'(want_beat.max_level), int'(out_data.max_level));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_session_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_session();
    test_interval_extremes();
    test_random_traffic();
    wait_quiet();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/psl_pkg.sv
rtl/psl_ram.sv
rtl/psl_sorter.sv
rtl/per_second_peak_level_statistics.sv
dv/tb_per_second_peak_level_statistics.sv
